[sv/rgb_to_v210_packer_defines.svh]
// Assertion macros shared by the RGB to v210 packer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RGB_TO_V210_PACKER_DEFINES_SVH
`define RGB_TO_V210_PACKER_DEFINES_SVH

// A condition that must hold on every clock edge out of reset.
`define R2V_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define R2V_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define R2V_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/r2v_pkg.sv]
// Shared types and constants for the RGB to v210 packer.
// No dependencies; imported by r2v_out_buf and rgb_to_v210_packer.
`default_nettype none

package r2v_pkg;

  // Sample and word geometry.
  localparam int SAMPLE_W         = 10;
  localparam int WORD_W           = 30;
  localparam int WORDS_PER_GROUP  = 4;
  localparam int PIXELS_PER_GROUP = 6;
  localparam int PAIRS_PER_GROUP  = 3;
  localparam int SAMPLE_MAX       = 1023;
  localparam int Y_OFFSET         = 64;
  localparam int C_OFFSET         = 512;

  // Configuration register indexes.
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ORDER = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COLOUR_SPACE  = 1'b1;
  localparam int CFG_DATA_W = 2;

  // Channel order codes.
  localparam logic ORDER_RGBA = 1'b0;
  localparam logic ORDER_BGRA = 1'b1;

  // Colour space codes; the spare code falls back to BT.709.
  localparam logic [1:0] CS_BT709  = 2'd0;
  localparam logic [1:0] CS_BT601  = 2'd1;
  localparam logic [1:0] CS_BT2020 = 2'd2;
  localparam int NUM_SPACES = 3;

  // Luma weights kr and kb in units of 1/10000, indexed by colour space code.
  localparam int KR_TAB [NUM_SPACES] = '{2126, 2990, 2627};
  localparam int KB_TAB [NUM_SPACES] = '{722, 1140, 593};

  // Coefficient slots within one colour space set.
  localparam int NUM_COEFS = 9;
  localparam int CI_YR  = 0;
  localparam int CI_YG  = 1;
  localparam int CI_YB  = 2;
  localparam int CI_CBR = 3;
  localparam int CI_CBG = 4;
  localparam int CI_CBB = 5;
  localparam int CI_CRR = 6;
  localparam int CI_CRG = 7;
  localparam int CI_CRB = 8;

  // A finished group handed to the output buffer.
  typedef struct packed {
    logic                                    load;
    logic [WORDS_PER_GROUP-1:0][WORD_W-1:0]  words;
  } load_t;

endpackage

`default_nettype wire

[sv/r2v_out_buf.sv]
// Output buffer for the RGB to v210 packer: holds one group of four v210
// words and sends them a beat at a time. Depends on r2v_pkg.
`default_nettype none
`include "rgb_to_v210_packer_defines.svh"

module r2v_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire r2v_pkg::load_t   load_i,
  output logic                  load_ok_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o,   // packed_word[29:0], zeros [31:30]
  output logic                  m_axis_tlast_o    // last_word
);
  import r2v_pkg::*;

  localparam int CNT_W = $clog2(WORDS_PER_GROUP + 1);

  logic [WORD_W-1:0] words_q [WORDS_PER_GROUP];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              beat;

  // A beat leaves the head word; the remaining count also marks the last word.
  assign beat            = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {(32 - WORD_W)'(0), words_q[0]};
  assign m_axis_tlast_o  = (cnt_q == CNT_W'(1));

  // A new group may enter once the buffer is empty or its last word leaves now.
  assign load_ok_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_axis_tready_i);

  // Count of words still to send.
  always_comb begin
    cnt_d = cnt_q;
    if (load_i.load) begin
      cnt_d = CNT_W'(WORDS_PER_GROUP);
    end else if (beat) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Word storage: load a whole group or shift towards the head on each beat.
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      for (int k = 0; k < WORDS_PER_GROUP; k++) begin
        words_q[k] <= load_i.words[k];
      end
    end else if (beat) begin
      for (int k = 0; k < WORDS_PER_GROUP - 1; k++) begin
        words_q[k] <= words_q[k+1];
      end
    end
  end

  `R2V_ASSERT_IMPL(a_load_allowed, load_i.load, load_ok_o, "group loaded over unsent words")
  `R2V_ASSERT_NEXT(a_full_after_load, load_i.load, cnt_q == CNT_W'(WORDS_PER_GROUP), "count not full after load")
  `R2V_ASSERT_NEXT(a_drain_end, beat && m_axis_tlast_o && !load_i.load, !m_axis_tvalid_o, "data shown after last word")

endmodule

`default_nettype wire

[sv/rgb_to_v210_packer.sv]
// Top level of the RGB to v210 packer: 8-bit RGB pixels in, 10-bit 4:2:2
// v210 words out. Depends on r2v_pkg and r2v_out_buf.
//
//   Channel   Direction  Beat carries
//   s_axis    in         byte0, byte1, byte2 in tdata; last_in_row in tlast
//   m_axis    out        packed_word in tdata; last_word in tlast
//   cfg       in         write of channel_order (index 0) or colour_space (1)
//
// One pixel is taken every cycle while the output buffer has room. A group
// leaves as four beats; the first is offered once the group has passed stages
// A, B and C and been loaded into the output buffer.
// The buffer holds one group, so a row end on every pixel holds the input while
// each group's four words drain. Reset clears the control state at once; the
// sample stores are not cleared and need no clearing pass.
`default_nettype none
`include "rgb_to_v210_packer_defines.svh"

module rgb_to_v210_packer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [r2v_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [r2v_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [23:0]                       s_axis_tdata_i,  // byte0, byte1, byte2
  input  wire logic                              s_axis_tlast_i,  // last_in_row
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [31:0]                            m_axis_tdata_o,  // packed_word, zero pad
  output logic                                   m_axis_tlast_o   // last_word
);
  import r2v_pkg::*;

  // Coefficient, product and accumulator widths.
  localparam int CW = FRAC_BITS + 3;
  localparam int PW = CW + 10;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] Y_RND = $signed(AW'(1) << (FRAC_BITS - 1));
  localparam logic signed [AW-1:0] C_RND = $signed(AW'(1) << FRAC_BITS);

  // Configuration registers.
  logic       order_q;
  logic [1:0] space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RGBA;
      space_q <= CS_BT709;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHANNEL_ORDER: order_q <= cfg_wdata_i[0];
        REG_COLOUR_SPACE:  space_q <= cfg_wdata_i;
      endcase
    end
  end

  // Coefficient table per colour space, worked out at elaboration.
  logic signed [CW-1:0] coef_tab [NUM_SPACES][NUM_COEFS];
  logic signed [CW-1:0] coef     [NUM_COEFS];

  for (genvar s = 0; s < NUM_SPACES; s++) begin : g_space
    localparam longint KR  = longint'(KR_TAB[s]);
    localparam longint KB  = longint'(KB_TAB[s]);
    localparam longint KG  = 10000 - KR - KB;
    localparam longint SC  = longint'(1) << (FRAC_BITS + 1);
    localparam longint DY  = 2550000;
    localparam longint DCB = 510 * (10000 - KB);
    localparam longint DCR = 510 * (10000 - KR);
    localparam longint YR  = (KR * 876 * SC + DY) / (2 * DY);
    localparam longint YG  = (KG * 876 * SC + DY) / (2 * DY);
    localparam longint YB  = (KB * 876 * SC + DY) / (2 * DY);
    localparam longint CBR = -((KR * 896 * SC + DCB) / (2 * DCB));
    localparam longint CBG = -((KG * 896 * SC + DCB) / (2 * DCB));
    localparam longint CMX = (896 * SC + 510) / 1020;
    localparam longint CRG = -((KG * 896 * SC + DCR) / (2 * DCR));
    localparam longint CRB = -((KB * 896 * SC + DCR) / (2 * DCR));

    assign coef_tab[s][CI_YR]  = CW'(YR);
    assign coef_tab[s][CI_YG]  = CW'(YG);
    assign coef_tab[s][CI_YB]  = CW'(YB);
    assign coef_tab[s][CI_CBR] = CW'(CBR);
    assign coef_tab[s][CI_CBG] = CW'(CBG);
    assign coef_tab[s][CI_CBB] = CW'(CMX);
    assign coef_tab[s][CI_CRR] = CW'(CMX);
    assign coef_tab[s][CI_CRG] = CW'(CRG);
    assign coef_tab[s][CI_CRB] = CW'(CRB);
  end

  // Select the set in force; the spare code uses BT.709.
  always_comb begin
    unique case (space_q)
      CS_BT601:  coef = coef_tab[1];
      CS_BT2020: coef = coef_tab[2];
      default:   coef = coef_tab[0];
    endcase
  end

  // Pipeline advance: held only while a finished group waits for the buffer.
  logic  move;
  logic  load_ok;
  load_t load;

  assign s_axis_tready_o = move;

  // Stage A: input register, bytes reordered into R, G, B.
  logic             va_q;
  logic [7:0]       rgb_a_q [3];
  logic             last_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (move) begin
      va_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      rgb_a_q[0] <= (order_q == ORDER_BGRA) ? s_axis_tdata_i[23:16] : s_axis_tdata_i[7:0];
      rgb_a_q[1] <= s_axis_tdata_i[15:8];
      rgb_a_q[2] <= (order_q == ORDER_BGRA) ? s_axis_tdata_i[7:0] : s_axis_tdata_i[23:16];
      last_a_q   <= s_axis_tlast_i;
    end
  end

  // Group position and the even pixel that waits for its partner.
  logic [2:0]  group_pos_q, group_pos_d;
  logic [23:0] held_q;
  logic [7:0]  held_rgb [3];

  assign held_rgb[0] = held_q[23:16];
  assign held_rgb[1] = held_q[15:8];
  assign held_rgb[2] = held_q[7:0];

  assign group_pos_d = (last_a_q || (group_pos_q == 3'(PIXELS_PER_GROUP - 1)))
                     ? 3'd0 : group_pos_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_pos_q <= '0;
      held_q      <= '0;
    end else if (move && va_q) begin
      group_pos_q <= group_pos_d;
      if (!group_pos_q[0]) begin
        held_q <= {rgb_a_q[0], rgb_a_q[1], rgb_a_q[2]};
      end
    end
  end

  // Stage B: pixel, pair sum and position.
  logic       vb_q;
  logic [7:0] pix_b_q [3];
  logic [8:0] sum_b_q [3];
  logic [2:0] pos_b_q;
  logic       last_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (move) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      for (int k = 0; k < 3; k++) begin
        pix_b_q[k] <= rgb_a_q[k];
        sum_b_q[k] <= {1'b0, held_rgb[k]} + {1'b0, rgb_a_q[k]};
      end
      pos_b_q  <= group_pos_q;
      last_b_q <= last_a_q;
    end
  end

  // Stage C: products of the pixel and of the pair sum with the coefficients.
  logic                 vc_q;
  logic signed [PW-1:0] py_q   [3];
  logic signed [PW-1:0] pcb_q  [3];
  logic signed [PW-1:0] pcr_q  [3];
  logic signed [PW-1:0] pcbp_q [3];
  logic signed [PW-1:0] pcrp_q [3];
  logic [2:0]           pos_c_q;
  logic                 last_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (move) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      for (int k = 0; k < 3; k++) begin
        py_q[k]   <= PW'(coef[CI_YR + k])  * PW'($signed({2'b00, pix_b_q[k]}));
        pcb_q[k]  <= PW'(coef[CI_CBR + k]) * PW'($signed({2'b00, pix_b_q[k]}));
        pcr_q[k]  <= PW'(coef[CI_CRR + k]) * PW'($signed({2'b00, pix_b_q[k]}));
        pcbp_q[k] <= PW'(coef[CI_CBR + k]) * PW'($signed({1'b0, sum_b_q[k]}));
        pcrp_q[k] <= PW'(coef[CI_CRR + k]) * PW'($signed({1'b0, sum_b_q[k]}));
      end
      pos_c_q  <= pos_b_q;
      last_c_q <= last_b_q;
    end
  end

  // Clamp a signed sample to the 10-bit range.
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [AW-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > AW'(SAMPLE_MAX)) begin
      r = '1;
    end else begin
      r = SAMPLE_W'(v);
    end
    return r;
  endfunction

  // Sample arithmetic: luma, pair chroma and doubled single-pixel chroma.
  logic signed [AW-1:0] acc_y, acc_cbp, acc_crp, acc_cbd, acc_crd;
  logic [SAMPLE_W-1:0]  y_val, cbp_val, crp_val, cbd_val, crd_val;

  always_comb begin
    acc_y   = AW'(py_q[0]) + AW'(py_q[1]) + AW'(py_q[2]) + Y_RND;
    acc_cbp = AW'(pcbp_q[0]) + AW'(pcbp_q[1]) + AW'(pcbp_q[2]) + C_RND;
    acc_crp = AW'(pcrp_q[0]) + AW'(pcrp_q[1]) + AW'(pcrp_q[2]) + C_RND;
    acc_cbd = ((AW'(pcb_q[0]) + AW'(pcb_q[1]) + AW'(pcb_q[2])) <<< 1) + C_RND;
    acc_crd = ((AW'(pcr_q[0]) + AW'(pcr_q[1]) + AW'(pcr_q[2])) <<< 1) + C_RND;
    y_val   = clamp_sample((acc_y >>> FRAC_BITS) + AW'(Y_OFFSET));
    cbp_val = clamp_sample((acc_cbp >>> (FRAC_BITS + 1)) + AW'(C_OFFSET));
    crp_val = clamp_sample((acc_crp >>> (FRAC_BITS + 1)) + AW'(C_OFFSET));
    cbd_val = clamp_sample((acc_cbd >>> (FRAC_BITS + 1)) + AW'(C_OFFSET));
    crd_val = clamp_sample((acc_crd >>> (FRAC_BITS + 1)) + AW'(C_OFFSET));
  end

  // Group stores and their next contents, with row-end padding.
  logic [SAMPLE_W-1:0] luma_q [PIXELS_PER_GROUP];
  logic [SAMPLE_W-1:0] cb_q   [PAIRS_PER_GROUP];
  logic [SAMPLE_W-1:0] cr_q   [PAIRS_PER_GROUP];
  logic [SAMPLE_W-1:0] luma_d [PIXELS_PER_GROUP];
  logic [SAMPLE_W-1:0] cb_d   [PAIRS_PER_GROUP];
  logic [SAMPLE_W-1:0] cr_d   [PAIRS_PER_GROUP];
  logic [1:0]          pair_c;
  logic                odd_c;
  logic                done_c;

  assign pair_c = pos_c_q[2:1];
  assign odd_c  = pos_c_q[0];
  assign done_c = last_c_q || (pos_c_q == 3'(PIXELS_PER_GROUP - 1));

  always_comb begin
    for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
      luma_d[k] = luma_q[k];
      if ((3'(k) == pos_c_q) || (last_c_q && (3'(k) > pos_c_q))) begin
        luma_d[k] = y_val;
      end
    end
    for (int j = 0; j < PAIRS_PER_GROUP; j++) begin
      cb_d[j] = cb_q[j];
      cr_d[j] = cr_q[j];
      if (((2'(j) == pair_c) && (odd_c || last_c_q)) || (last_c_q && (2'(j) > pair_c))) begin
        cb_d[j] = ((2'(j) == pair_c) && odd_c) ? cbp_val : cbd_val;
        cr_d[j] = ((2'(j) == pair_c) && odd_c) ? crp_val : crd_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && vc_q) begin
      luma_q <= luma_d;
      cb_q   <= cb_d;
      cr_q   <= cr_d;
    end
  end

  // Pack the finished group into four v210 words, low sample first.
  assign load.load     = vc_q && done_c && load_ok;
  assign load.words[0] = {cr_d[0], luma_d[0], cb_d[0]};
  assign load.words[1] = {luma_d[2], cb_d[1], luma_d[1]};
  assign load.words[2] = {cb_d[2], luma_d[3], cr_d[1]};
  assign load.words[3] = {luma_d[5], cr_d[2], luma_d[4]};

  assign move = !(vc_q && done_c && !load_ok);

  r2v_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .load_ok_o       (load_ok),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `R2V_ASSERT_IMPL(a_stall_cause, !s_axis_tready_o, m_axis_tvalid_o, "input stalled with no output pending")
  `R2V_ASSERT_ALWAYS(a_pos_range, group_pos_q <= 3'(PIXELS_PER_GROUP - 1), "group position out of range")
  `R2V_ASSERT_NEXT(a_row_end_wrap, move && va_q && last_a_q, group_pos_q == 3'd0, "row end did not restart the group")

endmodule

`default_nettype wire

[tb/tb_rgb_to_v210_packer.sv]
// Self-checking testbench for rgb_to_v210_packer: RGB pixel beats in, v210 word beats out.
// A built-in colour converter predicts every word; it depends on r2v_pkg and the block.
`timescale 1ns / 1ps

module tb_rgb_to_v210_packer;
  import r2v_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int SETTLE     = 12;   // cycles for the pipeline to go quiet
  localparam int TAIL_ITEMS = 30;   // final stretch run without idling
  localparam int HOLD_AT    = 32;   // word count that starts the long hold-off
  localparam int HOLD_LEN   = 160;
  localparam int LIMIT      = 2000; // cycles without any beat before giving up

  typedef enum logic [1:0] {ITEM_PIXEL, ITEM_CFG, ITEM_DRAIN} item_kind_e;

  typedef struct {
    item_kind_e                kind;
    logic [7:0]                b0, b1, b2;
    logic                      last;
    logic [REG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     val;
  } pend_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } v210_beat_t;

  typedef struct {
    longint yr, yg, yb, cbr, cbg, cbb, crr, crg, crb;
  } coef_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_idx   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    s_valid   = 1'b0;
  logic                    s_ready;
  logic [23:0]             s_tdata   = '0;
  logic                    s_tlast   = 1'b0;
  logic                    m_valid;
  logic                    m_ready   = 1'b0;
  logic [31:0]             m_tdata;
  logic                    m_tlast;

  pend_item_t  pixel_q[$];
  v210_beat_t  v210_words_q[$];
  int          errors = 0;

  // Predictor state: configuration and the group being assembled.
  logic        order_cfg = ORDER_RGBA;
  logic [1:0]  cs_cfg    = CS_BT709;
  int          grp_pos   = 0;
  int          held_r, held_g, held_b;
  logic [9:0]  luma_st[PIXELS_PER_GROUP];
  logic [9:0]  cb_st[PAIRS_PER_GROUP];
  logic [9:0]  cr_st[PAIRS_PER_GROUP];

  rgb_to_v210_packer #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),   // byte0, byte1, byte2
    .s_axis_tlast_i  (s_tlast),   // last_in_row
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),   // packed_word, zero pad
    .m_axis_tlast_o  (m_tlast)    // last_word
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Fixed-point coefficient, rounded half away from zero.
  function automatic longint round_q(longint unsigned num, longint unsigned den, bit neg);
    longint unsigned q;
    q = ((num << (FRAC_BITS + 1)) + den) / (2 * den);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic coef_t coefs_for(logic [1:0] cs);
    longint unsigned kr, kb, kg;
    coef_t c;
    case (cs)
      CS_BT601: begin
        kr = 2990; kb = 1140;
      end
      CS_BT2020: begin
        kr = 2627; kb = 593;
      end
      default: begin
        kr = 2126; kb = 722;
      end
    endcase
    kg    = 10000 - kr - kb;
    c.yr  = round_q(kr * 876, 2550000, 1'b0);
    c.yg  = round_q(kg * 876, 2550000, 1'b0);
    c.yb  = round_q(kb * 876, 2550000, 1'b0);
    c.cbr = round_q(kr * 896, 510 * (10000 - kb), 1'b1);
    c.cbg = round_q(kg * 896, 510 * (10000 - kb), 1'b1);
    c.cbb = round_q(896, 510, 1'b0);
    c.crr = round_q(896, 510, 1'b0);
    c.crg = round_q(kg * 896, 510 * (10000 - kr), 1'b1);
    c.crb = round_q(kb * 896, 510 * (10000 - kr), 1'b1);
    return c;
  endfunction

  function automatic logic [9:0] clamp10(longint v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return 10'(SAMPLE_MAX);
    return v[9:0];
  endfunction

  function automatic logic [9:0] luma_of(coef_t c, int r, int g, int b);
    longint acc;
    acc = c.yr * r + c.yg * g + c.yb * b + (longint'(1) << (FRAC_BITS - 1));
    return clamp10(Y_OFFSET + (acc >>> FRAC_BITS));
  endfunction

  function automatic logic [9:0] chroma_of(longint kr, longint kg, longint kb,
                                           int rs, int gs, int bs);
    longint acc;
    acc = kr * rs + kg * gs + kb * bs + (longint'(1) << FRAC_BITS);
    return clamp10(C_OFFSET + (acc >>> (FRAC_BITS + 1)));
  endfunction

  task automatic store_chroma(coef_t c, int pair, int rs, int gs, int bs);
    cb_st[pair] = chroma_of(c.cbr, c.cbg, c.cbb, rs, gs, bs);
    cr_st[pair] = chroma_of(c.crr, c.crg, c.crb, rs, gs, bs);
  endtask

  // Convert one accepted pixel; a completed group yields four v210 words.
  task automatic convert_pixel(pend_item_t p);
    coef_t      c;
    int         r, g, b, k;
    logic [9:0] y;
    c = coefs_for(cs_cfg);
    r = (order_cfg == ORDER_BGRA) ? p.b2 : p.b0;
    g = p.b1;
    b = (order_cfg == ORDER_BGRA) ? p.b0 : p.b2;
    k = (grp_pos > 5) ? 0 : grp_pos;
    y = luma_of(c, r, g, b);
    luma_st[k] = y;
    if (k % 2 == 0) begin
      held_r = r; held_g = g; held_b = b;
      if (p.last) store_chroma(c, k / 2, 2 * r, 2 * g, 2 * b);
    end else begin
      store_chroma(c, k / 2, held_r + r, held_g + g, held_b + b);
    end
    k++;
    // A row end pads the group with copies of its last pixel.
    if (p.last) begin
      for (int j = k; j < PIXELS_PER_GROUP; j++) begin
        luma_st[j] = y;
        if (j % 2 == 0) store_chroma(c, j / 2, 2 * r, 2 * g, 2 * b);
      end
      k = PIXELS_PER_GROUP;
    end
    if (k < PIXELS_PER_GROUP) begin
      grp_pos = k;
    end else begin
      grp_pos = 0;
      v210_words_q.push_back('{word: {cr_st[0], luma_st[0], cb_st[0]}, last: 1'b0});
      v210_words_q.push_back('{word: {luma_st[2], cb_st[1], luma_st[1]}, last: 1'b0});
      v210_words_q.push_back('{word: {cb_st[2], luma_st[3], cr_st[1]}, last: 1'b0});
      v210_words_q.push_back('{word: {luma_st[5], cr_st[2], luma_st[4]}, last: 1'b1});
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic last);
    pixel_q.push_back('{kind: ITEM_PIXEL, b0: b0, b1: b1, b2: b2, last: last,
                        idx: '0, val: '0});
  endtask

  task automatic add_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    pixel_q.push_back('{kind: ITEM_CFG, b0: '0, b1: '0, b2: '0, last: 1'b0,
                        idx: idx, val: val});
  endtask

  task automatic add_drain();
    pixel_q.push_back('{kind: ITEM_DRAIN, b0: '0, b1: '0, b2: '0, last: 1'b0,
                        idx: '0, val: '0});
  endtask

  // Pixel driver: issues beats, register writes and drain pauses in queue order.
  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    pend_item_t head;
    pend_item_t cur_pix;
    logic       nv;
    logic       nwe;
    int         tx_gap;
    int         tx_pct;
    int         tx_cnt;
    int         settle_cnt;
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      cfg_we     <= 1'b0;
      tx_gap     = 0;
      tx_pct     = 0;
      tx_cnt     = 0;
      settle_cnt = 0;
    end else begin
      nv  = s_valid;
      nwe = 1'b0;
      if (s_valid && s_ready) begin
        convert_pixel(cur_pix);
        nv = 1'b0;
      end
      tx_cnt++;
      if (tx_cnt % 64 == 0) tx_pct = pick_pct();
      if (!nv && pixel_q.size() != 0) begin
        head = pixel_q[0];
        case (head.kind)
          ITEM_PIXEL: begin
            if (tx_gap > 0) begin
              tx_gap--;
            end else if (pixel_q.size() >= TAIL_ITEMS &&
                         $urandom_range(0, 99) < tx_pct) begin
              tx_gap = $urandom_range(0, 8);
            end else begin
              cur_pix = head;
              void'(pixel_q.pop_front());
              nv = 1'b1;
              s_tdata <= {head.b2, head.b1, head.b0};
              s_tlast <= head.last;
            end
          end
          ITEM_CFG: begin
            nwe = 1'b1;
            cfg_idx   <= head.idx;
            cfg_wdata <= head.val;
            if (head.idx == REG_CHANNEL_ORDER) order_cfg = head.val[0];
            else cs_cfg = head.val;
            void'(pixel_q.pop_front());
          end
          default: begin
            // Hold off until every word is out and the pipeline has settled.
            if (v210_words_q.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt == SETTLE) begin
              settle_cnt = 0;
              void'(pixel_q.pop_front());
            end else begin
              settle_cnt++;
            end
          end
        endcase
      end
      s_valid <= nv;
      cfg_we  <= nwe;
    end
  end

  // Word monitor: random back-pressure, one long hold-off, compare with prediction.
  always @(posedge clk_i or negedge rst_ni) begin : take_words
    v210_beat_t want;
    logic       nr;
    int         rx_stall;
    int         rx_pct;
    int         rx_cnt;
    int         words_seen;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      rx_stall   = 0;
      rx_pct     = 0;
      rx_cnt     = 0;
      words_seen = 0;
    end else begin
      if (m_valid && m_ready) begin
        words_seen++;
        if (v210_words_q.size() == 0) begin
          $error("unexpected beat: packed_word %h, last_word %b", m_tdata[WORD_W-1:0],
                 m_tlast);
          errors++;
        end else begin
          want = v210_words_q.pop_front();
          if (m_tdata[WORD_W-1:0] !== want.word) begin
            $error("packed_word: expected %h, actual %h", want.word, m_tdata[WORD_W-1:0]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_word: expected %b, actual %b", want.last, m_tlast);
            errors++;
          end
        end
        if (words_seen == HOLD_AT) rx_stall = HOLD_LEN;
      end
      rx_cnt++;
      if (rx_cnt % 64 == 0) rx_pct = pick_pct();
      if (rx_stall > 0) begin
        rx_stall--;
        nr = 1'b0;
      end else if (pixel_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < rx_pct) begin
        rx_stall = $urandom_range(0, 8);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_ready <= nr;
    end
  end

  // Watchdog on cycles without any beat on either side.
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == LIMIT) begin
        $display("** rgb_to_v210_packer: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [1:0] ph_order [5] = '{1, 0, 1, 0, 1};
    logic [1:0] ph_cs    [5] = '{CS_BT709, CS_BT2020, CS_BT601, 2'd3, CS_BT2020};
    int         made;
    int         row_len;
    logic       noisy;
    logic       last;

    // Extremes and primaries at reset settings; the sixth pixel closes the group.
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    add_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
    // Row ending on the first pixel of a group.
    add_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    // Row ending on an odd position.
    add_pixel(8'd10, 8'd200, 8'd30, 1'b0);
    add_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
    // Row ending on an even position after a full pair.
    add_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    add_pixel(8'd254, 8'd253, 8'd252, 1'b0);
    add_pixel(8'd77, 8'd0, 8'd180, 1'b0);
    add_pixel(8'd0, 8'd99, 8'd255, 1'b0);
    add_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    // Extra value bits are masked: 3 written to channel order selects BGRA.
    add_drain();
    add_cfg(REG_CHANNEL_ORDER, 2'd3);
    add_cfg(REG_COLOUR_SPACE, CS_BT601);
    add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    // Registers change between the two pixels of a pair.
    add_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    add_drain();
    add_cfg(REG_COLOUR_SPACE, CS_BT2020);
    add_cfg(REG_CHANNEL_ORDER, ORDER_RGBA);
    add_pixel(8'd20, 8'd40, 8'd60, 1'b1);
    // The spare colour space code falls back to BT.709.
    add_drain();
    add_cfg(REG_COLOUR_SPACE, 2'd3);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'd128, 8'd128, 8'd128, 1'b1);

    // Random phases: mostly whole rows of random length, with some stray row ends.
    for (int ph = 0; ph < 5; ph++) begin
      add_drain();
      add_cfg(REG_CHANNEL_ORDER, ph_order[ph]);
      add_cfg(REG_COLOUR_SPACE, ph_cs[ph]);
      made = 0;
      while (made < 41) begin
        row_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 20);
        noisy   = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < row_len && made < 41; i++) begin
          last = (i == row_len - 1) || (made == 40) || (noisy && $urandom_range(0, 7) == 0);
          add_pixel(rand_byte(), rand_byte(), rand_byte(), last);
          made++;
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || s_valid) @(posedge clk_i);
    while (v210_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("** rgb_to_v210_packer: PASSED **");
    end else begin
      $display("** rgb_to_v210_packer: FAILED **");
    end
    $finish;
  end

endmodule
